// File: src/dlts_pkg.sv
// Shared types, character constants and byte classes for the token scanner.
// Used by every module of the block; depends on nothing.
package dlts_pkg;

  localparam int MAX_RES     = 3;
  localparam int QDEPTH      = 4;
  localparam int QPTR_BITS   = $clog2(QDEPTH);
  localparam int QCNT_BITS   = $clog2(QDEPTH + 1);
  localparam int RCNT_BITS   = $clog2(MAX_RES + 1);
  localparam int OUT_OFF_BITS = 32;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_US     = 8'h5F;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_LBRC   = 8'h7B;
  localparam logic [7:0] CH_RBRC   = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;

  typedef enum logic [3:0] {
    K_COMMA  = 4'd0,
    K_LPAR   = 4'd1,
    K_RPAR   = 4'd2,
    K_LBRK   = 4'd3,
    K_RBRK   = 4'd4,
    K_LBRC   = 4'd5,
    K_RBRC   = 4'd6,
    K_COLON  = 4'd7,
    K_STRING = 4'd8,
    K_NAME   = 4'd9,
    K_NUMBER = 4'd10,
    K_END    = 4'd11,
    K_ERROR  = 4'd12
  } kind_t;

  typedef enum logic [4:0] {
    M_IDLE       = 5'd0,
    M_SLASH      = 5'd1,
    M_LINE       = 5'd2,
    M_BLOCK      = 5'd3,
    M_BLOCK_STAR = 5'd4,
    M_SQ         = 5'd5,
    M_SQ_ESC     = 5'd6,
    M_DQ         = 5'd7,
    M_DQ_ESC     = 5'd8,
    M_NAME_US    = 5'd9,
    M_NAME       = 5'd10,
    M_NUM_SIGN   = 5'd11,
    M_NUM_INT    = 5'd12,
    M_NUM_DOT    = 5'd13,
    M_NUM_FRAC   = 5'd14,
    M_NUM_E      = 5'd15,
    M_NUM_ESIGN  = 5'd16,
    M_NUM_EXP    = 5'd17,
    M_DONE       = 5'd18
  } mode_t;

  typedef struct packed {
    logic                    item_type;
    logic [7:0]              text_byte;
    kind_t                   token_kind;
    logic [OUT_OFF_BITS-1:0] start_offset;
    logic [OUT_OFF_BITS-1:0] end_offset;
    logic                    last_of_run;
  } res_t;

  typedef struct packed {
    logic [RCNT_BITS-1:0]    count;
    res_t [MAX_RES-1:0]      res;
  } push_t;

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

  function automatic logic is_sign(logic [7:0] b);
    return (b == CH_PLUS) || (b == CH_MINUS);
  endfunction

  function automatic logic is_punct(logic [7:0] b);
    return (b == CH_COMMA) || (b == CH_LPAR) || (b == CH_RPAR) || (b == CH_LBRK) ||
           (b == CH_RBRK) || (b == CH_LBRC) || (b == CH_RBRC) || (b == CH_COLON);
  endfunction

  function automatic kind_t punct_kind(logic [7:0] b);
    kind_t k;
    unique case (b)
      CH_LPAR:  k = K_LPAR;
      CH_RPAR:  k = K_RPAR;
      CH_LBRK:  k = K_LBRK;
      CH_RBRK:  k = K_RBRK;
      CH_LBRC:  k = K_LBRC;
      CH_RBRC:  k = K_RBRC;
      CH_COLON: k = K_COLON;
      default:  k = K_COMMA;
    endcase
    return k;
  endfunction

endpackage

// File: src/dlts_scan.sv
// Scanner state machine: mode, byte position and word start, and the results
// one accepted item causes. Depends on dlts_pkg.
module dlts_scan #(
  parameter int OFFSET_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                end_mark,
  output dlts_pkg::push_t     push
);

  dlts_pkg::mode_t          mode, mode_next;
  logic [OFFSET_BITS-1:0]   pos, pos_next;
  logic [OFFSET_BITS-1:0]   wstart, wstart_next;
  logic [OFFSET_BITS-1:0]   pos_inc;
  logic                     restart;
  logic [dlts_pkg::RCNT_BITS-1:0] n;
  dlts_pkg::res_t [dlts_pkg::MAX_RES-1:0] r;

  function automatic logic [dlts_pkg::OUT_OFF_BITS-1:0] off_out(logic [OFFSET_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[dlts_pkg::OUT_OFF_BITS-1:0];
  endfunction

  function automatic dlts_pkg::res_t text_res(logic [7:0] b);
    dlts_pkg::res_t t;
    t = '0;
    t.text_byte = b;
    return t;
  endfunction

  function automatic dlts_pkg::res_t tok_res(dlts_pkg::kind_t k, logic [OFFSET_BITS-1:0] s,
                                              logic [OFFSET_BITS-1:0] e);
    dlts_pkg::res_t t;
    t = '0;
    t.item_type    = 1'b1;
    t.token_kind   = k;
    t.start_offset = off_out(s);
    t.end_offset   = off_out(e);
    return t;
  endfunction

  assign pos_inc = (&pos) ? pos : pos + 1'b1;

  always_comb begin
    mode_next   = mode;
    wstart_next = wstart;
    pos_next    = end_mark ? pos : pos_inc;
    restart     = 1'b0;
    if (end_mark) begin
      mode_next = dlts_pkg::M_DONE;
    end else begin
      unique case (mode)
        dlts_pkg::M_DONE: ;
        dlts_pkg::M_SLASH: begin
          if (data_byte == dlts_pkg::CH_SLASH) mode_next = dlts_pkg::M_LINE;
          else if (data_byte == dlts_pkg::CH_STAR) mode_next = dlts_pkg::M_BLOCK;
          else mode_next = dlts_pkg::M_DONE;
        end
        dlts_pkg::M_LINE: begin
          if (data_byte == dlts_pkg::CH_LF || data_byte == dlts_pkg::CH_CR)
            mode_next = dlts_pkg::M_IDLE;
        end
        dlts_pkg::M_BLOCK: begin
          if (data_byte == dlts_pkg::CH_STAR) mode_next = dlts_pkg::M_BLOCK_STAR;
        end
        dlts_pkg::M_BLOCK_STAR: begin
          if (data_byte == dlts_pkg::CH_SLASH) mode_next = dlts_pkg::M_IDLE;
          else if (data_byte != dlts_pkg::CH_STAR) mode_next = dlts_pkg::M_BLOCK;
        end
        dlts_pkg::M_SQ: begin
          if (data_byte == dlts_pkg::CH_SQUOTE) mode_next = dlts_pkg::M_IDLE;
          else if (data_byte == dlts_pkg::CH_BSL) mode_next = dlts_pkg::M_SQ_ESC;
        end
        dlts_pkg::M_DQ: begin
          if (data_byte == dlts_pkg::CH_DQUOTE) mode_next = dlts_pkg::M_IDLE;
          else if (data_byte == dlts_pkg::CH_BSL) mode_next = dlts_pkg::M_DQ_ESC;
        end
        dlts_pkg::M_SQ_ESC: mode_next = dlts_pkg::M_SQ;
        dlts_pkg::M_DQ_ESC: mode_next = dlts_pkg::M_DQ;
        dlts_pkg::M_NAME_US: begin
          if (dlts_pkg::is_alpha(data_byte)) mode_next = dlts_pkg::M_NAME;
          else if (data_byte != dlts_pkg::CH_US) mode_next = dlts_pkg::M_DONE;
        end
        dlts_pkg::M_NAME: begin
          if (!(dlts_pkg::is_alpha(data_byte) || dlts_pkg::is_digit(data_byte) ||
                data_byte == dlts_pkg::CH_US)) restart = 1'b1;
        end
        dlts_pkg::M_NUM_SIGN: begin
          if (dlts_pkg::is_digit(data_byte)) mode_next = dlts_pkg::M_NUM_INT;
          else if (data_byte == dlts_pkg::CH_DOT) mode_next = dlts_pkg::M_NUM_DOT;
          else mode_next = dlts_pkg::M_DONE;
        end
        dlts_pkg::M_NUM_INT: begin
          if (data_byte == dlts_pkg::CH_DOT) mode_next = dlts_pkg::M_NUM_FRAC;
          else if (data_byte == dlts_pkg::CH_E) mode_next = dlts_pkg::M_NUM_E;
          else if (!dlts_pkg::is_digit(data_byte)) restart = 1'b1;
        end
        dlts_pkg::M_NUM_DOT: begin
          if (dlts_pkg::is_digit(data_byte)) mode_next = dlts_pkg::M_NUM_FRAC;
          else mode_next = dlts_pkg::M_DONE;
        end
        dlts_pkg::M_NUM_FRAC: begin
          if (data_byte == dlts_pkg::CH_E) mode_next = dlts_pkg::M_NUM_E;
          else if (!dlts_pkg::is_digit(data_byte)) restart = 1'b1;
        end
        dlts_pkg::M_NUM_E: begin
          if (dlts_pkg::is_sign(data_byte)) mode_next = dlts_pkg::M_NUM_ESIGN;
          else if (dlts_pkg::is_digit(data_byte)) mode_next = dlts_pkg::M_NUM_EXP;
          else mode_next = dlts_pkg::M_DONE;
        end
        dlts_pkg::M_NUM_ESIGN: begin
          if (dlts_pkg::is_digit(data_byte)) mode_next = dlts_pkg::M_NUM_EXP;
          else mode_next = dlts_pkg::M_DONE;
        end
        dlts_pkg::M_NUM_EXP: begin
          if (!dlts_pkg::is_digit(data_byte)) restart = 1'b1;
        end
        default: restart = 1'b1;
      endcase
      if (restart) begin
        wstart_next = pos;
        mode_next   = dlts_pkg::M_IDLE;
        if (dlts_pkg::is_space(data_byte) || dlts_pkg::is_punct(data_byte))
          mode_next = dlts_pkg::M_IDLE;
        else if (data_byte == dlts_pkg::CH_SLASH) mode_next = dlts_pkg::M_SLASH;
        else if (data_byte == dlts_pkg::CH_SQUOTE) mode_next = dlts_pkg::M_SQ;
        else if (data_byte == dlts_pkg::CH_DQUOTE) mode_next = dlts_pkg::M_DQ;
        else if (dlts_pkg::is_digit(data_byte)) mode_next = dlts_pkg::M_NUM_INT;
        else if (dlts_pkg::is_sign(data_byte)) mode_next = dlts_pkg::M_NUM_SIGN;
        else if (data_byte == dlts_pkg::CH_DOT) mode_next = dlts_pkg::M_NUM_DOT;
        else if (data_byte == dlts_pkg::CH_US) mode_next = dlts_pkg::M_NAME_US;
        else if (dlts_pkg::is_alpha(data_byte)) mode_next = dlts_pkg::M_NAME;
        else mode_next = dlts_pkg::M_DONE;
      end
    end
  end

  always_comb begin
    n = '0;
    r = '0;
    if (end_mark) begin
      unique case (mode)
        dlts_pkg::M_DONE: ;
        dlts_pkg::M_IDLE, dlts_pkg::M_LINE: begin
          r[n] = tok_res(dlts_pkg::K_END, pos, pos); n = n + 1'b1;
        end
        dlts_pkg::M_NAME: begin
          r[n] = tok_res(dlts_pkg::K_NAME, wstart, pos); n = n + 1'b1;
          r[n] = tok_res(dlts_pkg::K_END, pos, pos); n = n + 1'b1;
        end
        dlts_pkg::M_NUM_INT, dlts_pkg::M_NUM_FRAC, dlts_pkg::M_NUM_EXP: begin
          r[n] = tok_res(dlts_pkg::K_NUMBER, wstart, pos); n = n + 1'b1;
          r[n] = tok_res(dlts_pkg::K_END, pos, pos); n = n + 1'b1;
        end
        default: begin
          r[n] = tok_res(dlts_pkg::K_ERROR, wstart, pos); n = n + 1'b1;
        end
      endcase
    end else begin
      unique case (mode)
        dlts_pkg::M_SLASH: begin
          if (data_byte != dlts_pkg::CH_SLASH && data_byte != dlts_pkg::CH_STAR) begin
            r[n] = tok_res(dlts_pkg::K_ERROR, wstart, pos); n = n + 1'b1;
          end
        end
        dlts_pkg::M_SQ, dlts_pkg::M_DQ: begin
          if ((mode == dlts_pkg::M_SQ && data_byte == dlts_pkg::CH_SQUOTE) ||
              (mode == dlts_pkg::M_DQ && data_byte == dlts_pkg::CH_DQUOTE)) begin
            r[n] = tok_res(dlts_pkg::K_STRING, wstart, pos_inc); n = n + 1'b1;
          end else if (data_byte != dlts_pkg::CH_BSL) begin
            r[n] = text_res(data_byte); n = n + 1'b1;
          end
        end
        dlts_pkg::M_SQ_ESC, dlts_pkg::M_DQ_ESC: begin
          r[n] = text_res(data_byte); n = n + 1'b1;
        end
        dlts_pkg::M_NAME_US: begin
          if (data_byte == dlts_pkg::CH_US || dlts_pkg::is_alpha(data_byte)) begin
            r[n] = text_res(data_byte); n = n + 1'b1;
          end else begin
            r[n] = tok_res(dlts_pkg::K_ERROR, wstart, pos); n = n + 1'b1;
          end
        end
        dlts_pkg::M_NAME: begin
          if (restart) begin
            r[n] = tok_res(dlts_pkg::K_NAME, wstart, pos); n = n + 1'b1;
          end else begin
            r[n] = text_res(data_byte); n = n + 1'b1;
          end
        end
        dlts_pkg::M_NUM_SIGN: begin
          if (dlts_pkg::is_digit(data_byte) || data_byte == dlts_pkg::CH_DOT) begin
            r[n] = text_res(data_byte); n = n + 1'b1;
          end else begin
            r[n] = tok_res(dlts_pkg::K_ERROR, wstart, pos); n = n + 1'b1;
          end
        end
        dlts_pkg::M_NUM_DOT, dlts_pkg::M_NUM_ESIGN: begin
          if (dlts_pkg::is_digit(data_byte)) begin
            r[n] = text_res(data_byte); n = n + 1'b1;
          end else begin
            r[n] = tok_res(dlts_pkg::K_ERROR, wstart, pos); n = n + 1'b1;
          end
        end
        dlts_pkg::M_NUM_E: begin
          if (dlts_pkg::is_digit(data_byte) || dlts_pkg::is_sign(data_byte)) begin
            r[n] = text_res(data_byte); n = n + 1'b1;
          end else begin
            r[n] = tok_res(dlts_pkg::K_ERROR, wstart, pos); n = n + 1'b1;
          end
        end
        dlts_pkg::M_NUM_INT, dlts_pkg::M_NUM_FRAC, dlts_pkg::M_NUM_EXP: begin
          if (restart) begin
            r[n] = tok_res(dlts_pkg::K_NUMBER, wstart, pos); n = n + 1'b1;
          end else begin
            r[n] = text_res(data_byte); n = n + 1'b1;
          end
        end
        default: ;
      endcase
      if (restart) begin
        if (dlts_pkg::is_punct(data_byte)) begin
          r[n] = text_res(data_byte); n = n + 1'b1;
          r[n] = tok_res(dlts_pkg::punct_kind(data_byte), pos, pos_inc); n = n + 1'b1;
        end else if (dlts_pkg::is_space(data_byte) || data_byte == dlts_pkg::CH_SLASH ||
                     data_byte == dlts_pkg::CH_SQUOTE || data_byte == dlts_pkg::CH_DQUOTE) begin
          n = n;
        end else if (dlts_pkg::is_digit(data_byte) || dlts_pkg::is_sign(data_byte) ||
                     data_byte == dlts_pkg::CH_DOT || data_byte == dlts_pkg::CH_US ||
                     dlts_pkg::is_alpha(data_byte)) begin
          r[n] = text_res(data_byte); n = n + 1'b1;
        end else begin
          r[n] = tok_res(dlts_pkg::K_ERROR, pos, pos); n = n + 1'b1;
        end
      end
    end
    if (n != '0) r[n - 1'b1].last_of_run = 1'b1;
  end

  assign push.count = accept ? n : '0;
  assign push.res   = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= dlts_pkg::M_IDLE;
      pos    <= '0;
      wstart <= '0;
    end else if (accept) begin
      mode   <= mode_next;
      pos    <= pos_next;
      wstart <= wstart_next;
    end
  end

endmodule

// File: src/dlts_queue.sv
// Result queue: takes up to three results per cycle, hands out one per cycle while pop is high.
// Depends on dlts_pkg.
module dlts_queue (
  input  logic            clk,
  input  logic            rst,
  input  dlts_pkg::push_t push,
  input  logic            pop,
  output logic            room,
  output logic            not_empty,
  output dlts_pkg::res_t  head
);

  dlts_pkg::res_t q [dlts_pkg::QDEPTH];
  logic [dlts_pkg::QPTR_BITS-1:0] rd, wr;
  logic [dlts_pkg::QCNT_BITS-1:0] count;
  logic do_pop;

  assign not_empty = (count != '0);
  assign do_pop    = pop && not_empty;
  assign room      = (count <= dlts_pkg::QCNT_BITS'(dlts_pkg::QDEPTH - dlts_pkg::MAX_RES));
  assign head      = q[rd];

  always_ff @(posedge clk) begin
    for (int i = 0; i < dlts_pkg::MAX_RES; i++) begin
      if (dlts_pkg::RCNT_BITS'(i) < push.count) q[wr + dlts_pkg::QPTR_BITS'(i)] <= push.res[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd    <= '0;
      wr    <= '0;
      count <= '0;
    end else begin
      wr    <= wr + dlts_pkg::QPTR_BITS'(push.count);
      rd    <= rd + dlts_pkg::QPTR_BITS'(do_pop);
      count <= count + dlts_pkg::QCNT_BITS'(push.count) - dlts_pkg::QCNT_BITS'(do_pop);
    end
  end

endmodule

// File: src/data_language_token_scanner.sv
// Top level of the token scanner: scanner state machine and result queue.
// Depends on dlts_pkg, dlts_scan and dlts_queue.
//
// Input channel: one source byte, or an end mark, per item on in_valid/in_stall.
// Output channel: one result per item on out_valid/out_stall; a result is
// either a text byte of the current word or a token record, and last_of_run
// marks the final result caused by one input item.
// Results of an accepted item are registered in the queue and reach the output
// behind any results still waiting. An item is taken every cycle while each item
// causes at most one result and out_stall is low; the four-entry queue holds an
// item with two or three results and in_stall rises while more than one result
// waits. A byte that closes a word and opens another causes up to three results.
// After an error or end token all further items are taken and give nothing.
// Reset (rst, synchronous) empties the queue, clears the byte position and
// returns the scanner to idle; in_stall is high during reset.
// While the receiver holds out_stall the head result stays on the port.
module data_language_token_scanner #(
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_mark,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        item_type,
  output logic [7:0]  text_byte,
  output logic [3:0]  token_kind,
  output logic [31:0] start_offset,
  output logic [31:0] end_offset,
  output logic        last_of_run
);

  dlts_pkg::push_t push;
  dlts_pkg::res_t  head;
  logic            room;
  logic            accept;

  assign in_stall = rst || !room;
  assign accept   = in_valid && !in_stall;

  dlts_scan #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .end_mark  (end_mark),
    .push      (push)
  );

  dlts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (!out_stall),
    .room      (room),
    .not_empty (out_valid),
    .head      (head)
  );

  assign item_type    = head.item_type;
  assign text_byte    = head.text_byte;
  assign token_kind   = head.token_kind;
  assign start_offset = head.start_offset;
  assign end_offset   = head.end_offset;
  assign last_of_run  = head.last_of_run;

endmodule

// File: src/dlts_checker.sv
// Port-level checks for the token scanner, bound to the top level.
// Depends on dlts_pkg and data_language_token_scanner.
module dlts_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        item_type,
  input logic [7:0]  text_byte,
  input logic [3:0]  token_kind,
  input logic [31:0] start_offset,
  input logic [31:0] end_offset,
  input logic        last_of_run
);

  a_reset_empty: assert property (@(posedge clk) rst |-> in_stall ##1 !out_valid)
    else $error("input open during reset or output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(item_type) && $stable(text_byte) &&
      $stable(token_kind) && $stable(start_offset) && $stable(end_offset))
    else $error("stalled result changed");

  a_text_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !item_type |-> token_kind == 4'd0 && start_offset == '0 && end_offset == '0)
    else $error("text item carries token fields");

  a_final_token: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_type && (token_kind == dlts_pkg::K_END || token_kind == dlts_pkg::K_ERROR)
      |-> last_of_run && text_byte == 8'd0)
    else $error("end or error token is not last of its run");

  a_end_span: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_type && token_kind == dlts_pkg::K_END |-> start_offset == end_offset)
    else $error("end token spans bytes");

endmodule

bind data_language_token_scanner dlts_checker u_dlts_checker (.*);

// File: bench/tb_top.sv
// Self-checking bench for data_language_token_scanner: byte stream in, text and token items out.
// Needs dlts_pkg for the byte constants, the token kinds, the scan modes and the result record.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dlts_pkg::*;

  localparam int ITEMS    = 470;
  localparam int WATCHDOG = 4000;
  localparam int DRAIN    = 16;
  localparam int HOLD     = 64;

  typedef enum int {PH_NONE, PH_SEND, PH_RECV, PH_BOTH, PH_PRESSURE} pace_t;

  localparam logic [7:0] OPENING [0:27] = '{
    CH_LBRC, CH_US, 8'h61, 8'h39, CH_COLON, CH_LBRK, CH_MINUS, 8'h31, CH_DOT, 8'h35,
    CH_E, CH_PLUS, 8'h33, CH_COMMA, CH_SQUOTE, CH_BSL, CH_SQUOTE, CH_SQUOTE, CH_RBRK,
    CH_RBRC, CH_LPAR, CH_DOT, 8'h35, CH_RPAR, CH_DQUOTE, 8'h00, 8'hFF, CH_DQUOTE};
  localparam logic [7:0] PUNCT_SET [0:7] = '{
    CH_COMMA, CH_LPAR, CH_RPAR, CH_LBRK, CH_RBRK, CH_LBRC, CH_RBRC, CH_COLON};
  localparam logic [7:0] SPACE_SET [0:3] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
  localparam logic [7:0] STRAY_SET [0:7] = '{
    8'h00, 8'hFF, 8'h23, 8'h40, CH_STAR, 8'h21, 8'h7E, 8'h80};

  class lexer_check;
    mode_t       mode;
    logic [31:0] pos;
    logic [31:0] wstart;
    res_t        step_out[$];
    res_t        due[$];
    int          errors;

    function new();
      mode   = M_IDLE;
      pos    = '0;
      wstart = '0;
      errors = 0;
    endfunction

    function logic [31:0] bump(logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
    endfunction

    function bit digit(logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function bit letter(logic [7:0] b);
      return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function void put(logic t, logic [7:0] b, kind_t k, logic [31:0] s, logic [31:0] e);
      res_t r;
      r              = '0;
      r.item_type    = t;
      r.text_byte    = b;
      r.token_kind   = k;
      r.start_offset = s;
      r.end_offset   = e;
      step_out.push_back(r);
    endfunction

    function void give_text(logic [7:0] b);
      put(1'b0, b, K_COMMA, '0, '0);
    endfunction

    function void give_token(kind_t k, logic [31:0] s, logic [31:0] e);
      put(1'b1, 8'h00, k, s, e);
    endfunction

    function void abort(logic [31:0] at);
      give_token(K_ERROR, wstart, at);
      mode = M_DONE;
    endfunction

    function void open_word(logic [7:0] b, logic [31:0] p);
      kind_t k;
      bit    hit;
      wstart = p;
      mode   = M_IDLE;
      hit    = 1'b1;
      k      = K_COMMA;
      case (b)
        CH_COMMA: k = K_COMMA;
        CH_LPAR:  k = K_LPAR;
        CH_RPAR:  k = K_RPAR;
        CH_LBRK:  k = K_LBRK;
        CH_RBRK:  k = K_RBRK;
        CH_LBRC:  k = K_LBRC;
        CH_RBRC:  k = K_RBRC;
        CH_COLON: k = K_COLON;
        default:  hit = 1'b0;
      endcase
      if (hit) begin
        give_text(b);
        give_token(k, p, bump(p));
      end else if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF) begin
      end else if (b == CH_SLASH) begin
        mode = M_SLASH;
      end else if (b == CH_SQUOTE) begin
        mode = M_SQ;
      end else if (b == CH_DQUOTE) begin
        mode = M_DQ;
      end else if (digit(b)) begin
        give_text(b);
        mode = M_NUM_INT;
      end else if (b == CH_PLUS || b == CH_MINUS) begin
        give_text(b);
        mode = M_NUM_SIGN;
      end else if (b == CH_DOT) begin
        give_text(b);
        mode = M_NUM_DOT;
      end else if (b == CH_US) begin
        give_text(b);
        mode = M_NAME_US;
      end else if (letter(b)) begin
        give_text(b);
        mode = M_NAME;
      end else begin
        abort(p);
      end
    endfunction

    function void split(kind_t k, logic [7:0] b, logic [31:0] p);
      give_token(k, wstart, p);
      open_word(b, p);
    endfunction

    function void next_byte(logic [7:0] b, logic [31:0] p);
      case (mode)
        M_DONE: ;
        M_SLASH: begin
          if (b == CH_SLASH) mode = M_LINE;
          else if (b == CH_STAR) mode = M_BLOCK;
          else abort(p);
        end
        M_LINE: if (b == CH_LF || b == CH_CR) mode = M_IDLE;
        M_BLOCK: if (b == CH_STAR) mode = M_BLOCK_STAR;
        M_BLOCK_STAR: begin
          if (b == CH_SLASH) mode = M_IDLE;
          else if (b != CH_STAR) mode = M_BLOCK;
        end
        M_SQ: begin
          if (b == CH_SQUOTE) begin
            give_token(K_STRING, wstart, bump(p));
            mode = M_IDLE;
          end else if (b == CH_BSL) begin
            mode = M_SQ_ESC;
          end else begin
            give_text(b);
          end
        end
        M_DQ: begin
          if (b == CH_DQUOTE) begin
            give_token(K_STRING, wstart, bump(p));
            mode = M_IDLE;
          end else if (b == CH_BSL) begin
            mode = M_DQ_ESC;
          end else begin
            give_text(b);
          end
        end
        M_SQ_ESC: begin
          give_text(b);
          mode = M_SQ;
        end
        M_DQ_ESC: begin
          give_text(b);
          mode = M_DQ;
        end
        M_NAME_US: begin
          if (b == CH_US) give_text(b);
          else if (letter(b)) begin
            give_text(b);
            mode = M_NAME;
          end else abort(p);
        end
        M_NAME: begin
          if (letter(b) || digit(b) || b == CH_US) give_text(b);
          else split(K_NAME, b, p);
        end
        M_NUM_SIGN: begin
          if (digit(b)) begin
            give_text(b);
            mode = M_NUM_INT;
          end else if (b == CH_DOT) begin
            give_text(b);
            mode = M_NUM_DOT;
          end else abort(p);
        end
        M_NUM_INT: begin
          if (digit(b)) give_text(b);
          else if (b == CH_DOT) begin
            give_text(b);
            mode = M_NUM_FRAC;
          end else if (b == CH_E) begin
            give_text(b);
            mode = M_NUM_E;
          end else split(K_NUMBER, b, p);
        end
        M_NUM_DOT: begin
          if (digit(b)) begin
            give_text(b);
            mode = M_NUM_FRAC;
          end else abort(p);
        end
        M_NUM_FRAC: begin
          if (digit(b)) give_text(b);
          else if (b == CH_E) begin
            give_text(b);
            mode = M_NUM_E;
          end else split(K_NUMBER, b, p);
        end
        M_NUM_E: begin
          if (b == CH_PLUS || b == CH_MINUS) begin
            give_text(b);
            mode = M_NUM_ESIGN;
          end else if (digit(b)) begin
            give_text(b);
            mode = M_NUM_EXP;
          end else abort(p);
        end
        M_NUM_ESIGN: begin
          if (digit(b)) begin
            give_text(b);
            mode = M_NUM_EXP;
          end else abort(p);
        end
        M_NUM_EXP: begin
          if (digit(b)) give_text(b);
          else split(K_NUMBER, b, p);
        end
        default: open_word(b, p);
      endcase
    endfunction

    function void absorb(logic [7:0] b, logic e);
      logic [31:0] p;
      bit          ended;
      p     = pos;
      ended = 1'b0;
      step_out.delete();
      if (e) begin
        case (mode)
          M_DONE: ;
          M_IDLE, M_LINE: ended = 1'b1;
          M_NAME: begin
            give_token(K_NAME, wstart, p);
            ended = 1'b1;
          end
          M_NUM_INT, M_NUM_FRAC, M_NUM_EXP: begin
            give_token(K_NUMBER, wstart, p);
            ended = 1'b1;
          end
          default: abort(p);
        endcase
        if (ended) begin
          give_token(K_END, p, p);
          mode = M_DONE;
        end
      end else begin
        next_byte(b, p);
        pos = bump(p);
      end
      if (step_out.size() != 0) begin
        step_out[step_out.size() - 1].last_of_run = 1'b1;
        foreach (step_out[i]) due.push_back(step_out[i]);
      end
    endfunction

    function void cmp(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void compare_result(logic t, logic [7:0] b, logic [3:0] k, logic [31:0] s,
                                 logic [31:0] e, logic l);
      res_t want;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none, actual type %0h byte %0h kind %0d %0h..%0h",
                 $time, t, b, k, s, e);
      end else begin
        want = due.pop_front();
        cmp("item_type", 32'(want.item_type), 32'(t));
        cmp("text_byte", 32'(want.text_byte), 32'(b));
        cmp("token_kind", 32'(want.token_kind), 32'(k));
        cmp("start_offset", want.start_offset, s);
        cmp("end_offset", want.end_offset, e);
        cmp("last_of_run", 32'(want.last_of_run), 32'(l));
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        end_mark  = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        item_type;
  logic [7:0]  text_byte;
  logic [3:0]  token_kind;
  logic [31:0] start_offset;
  logic [31:0] end_offset;
  logic        last_of_run;

  lexer_check  lex = new();
  pace_t       pace = PH_NONE;
  int          bytes_sent = 0;
  int          hold_left = 0;
  bit          pressed = 1'b0;
  bit          prev_open = 1'b0;
  logic [7:0]  word[$];

  data_language_token_scanner #(.OFFSET_BITS(32)) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .end_mark     (end_mark),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .item_type    (item_type),
    .text_byte    (text_byte),
    .token_kind   (token_kind),
    .start_offset (start_offset),
    .end_offset   (end_offset),
    .last_of_run  (last_of_run)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'h30 + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(1) != 0 ? 8'h41 : 8'h61) + 8'($urandom_range(25));
  endfunction

  function automatic void add_digits();
    repeat ($urandom_range(4, 1)) word.push_back(rand_digit());
  endfunction

  task automatic send_item(input logic [7:0] b, input logic e);
    int pct;
    pace = pace_t'((bytes_sent / 60) % 5);
    case (pace)
      PH_SEND: pct = 79;
      PH_BOTH: pct = 8;
      default: pct = 0;
    endcase
    while ($urandom_range(99) < pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    end_mark  <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lex.absorb(b, e);
    bytes_sent++;
  endtask

  task automatic random_word();
    int         pick;
    bit         opens;
    logic [7:0] q;
    logic [7:0] c;
    word.delete();
    pick  = $urandom_range(99);
    opens = (pick >= 20) && (pick < 58);
    if (opens && prev_open) word.push_back(SPACE_SET[$urandom_range(3)]);
    if (pick < 20) begin
      word.push_back(PUNCT_SET[$urandom_range(7)]);
    end else if (pick < 38) begin
      repeat ($urandom_range(2)) word.push_back(CH_US);
      word.push_back(rand_letter());
      repeat ($urandom_range(5)) begin
        case ($urandom_range(2))
          0: word.push_back(rand_letter());
          1: word.push_back(rand_digit());
          default: word.push_back(CH_US);
        endcase
      end
    end else if (pick < 58) begin
      if ($urandom_range(2) == 0) word.push_back($urandom_range(1) != 0 ? CH_PLUS : CH_MINUS);
      case ($urandom_range(3))
        0: add_digits();
        1: begin
          add_digits();
          word.push_back(CH_DOT);
          add_digits();
        end
        2: begin
          add_digits();
          word.push_back(CH_DOT);
        end
        default: begin
          word.push_back(CH_DOT);
          add_digits();
        end
      endcase
      if ($urandom_range(2) == 0) begin
        word.push_back(CH_E);
        case ($urandom_range(2))
          0: word.push_back(CH_PLUS);
          1: word.push_back(CH_MINUS);
          default: ;
        endcase
        add_digits();
      end
    end else if (pick < 74) begin
      q = ($urandom_range(1) != 0) ? CH_SQUOTE : CH_DQUOTE;
      word.push_back(q);
      repeat ($urandom_range(6)) begin
        c = rand_byte();
        if (c == q || c == CH_BSL || $urandom_range(4) == 0) word.push_back(CH_BSL);
        word.push_back(c);
      end
      word.push_back(q);
    end else if (pick < 86) begin
      repeat ($urandom_range(3, 1)) word.push_back(SPACE_SET[$urandom_range(3)]);
    end else if (pick < 92) begin
      word.push_back(CH_SLASH);
      word.push_back(CH_SLASH);
      repeat ($urandom_range(8)) begin
        c = rand_byte();
        word.push_back((c == CH_LF || c == CH_CR) ? CH_TAB : c);
      end
      word.push_back(($urandom_range(1) != 0) ? CH_LF : CH_CR);
    end else begin
      word.push_back(CH_SLASH);
      word.push_back(CH_STAR);
      repeat ($urandom_range(8)) begin
        c = rand_byte();
        word.push_back((c == CH_SLASH) ? CH_STAR : c);
      end
      repeat ($urandom_range(2, 1)) word.push_back(CH_STAR);
      word.push_back(CH_SLASH);
    end
    prev_open = opens;
    foreach (word[i]) send_item(word[i], 1'b0);
  endtask

  task automatic closing_word();
    word.delete();
    word.push_back(CH_SPACE);
    case ($urandom_range(15))
      1: word = {word, CH_SLASH, CH_SLASH, 8'h61, 8'h62};
      2: word = {word, CH_SLASH, 8'h61};
      3: word.push_back(CH_SLASH);
      4: word = {word, CH_SLASH, CH_STAR, 8'h61, CH_STAR};
      5: word = {word, CH_SQUOTE, 8'h61, 8'h62};
      6: word = {word, CH_DQUOTE, 8'h61, CH_BSL};
      7: word.push_back(STRAY_SET[$urandom_range(7)]);
      8: word.push_back(CH_MINUS);
      9: word = {word, CH_PLUS, 8'h78};
      10: word = {word, CH_DOT, 8'h78};
      11: word = {word, 8'h31, CH_E, CH_PLUS};
      12: word = {word, CH_US, CH_US, 8'h39};
      13: word = {word, 8'h61, 8'h62};
      14: word = {word, 8'h37, CH_DOT, 8'h35, CH_E, 8'h33};
      15: word = {word, 8'h34, CH_DOT};
      default: ;
    endcase
    foreach (word[i]) send_item(word[i], 1'b0);
    send_item(rand_byte(), 1'b1);
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (pace == PH_PRESSURE && !pressed) begin
      out_stall <= 1'b1;
      hold_left <= HOLD - 1;
      pressed   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < ((pace == PH_RECV) ? 79 : (pace == PH_BOTH) ? 8 : 0));
      if (pace != PH_PRESSURE) pressed <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      lex.compare_result(item_type, text_byte, token_kind, start_offset, end_offset, last_of_run);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (OPENING[i]) send_item(OPENING[i], 1'b0);
    while (bytes_sent < ITEMS) random_word();
    closing_word();
    repeat (6) send_item(rand_byte(), 1'($urandom_range(1)));
    in_valid <= 1'b0;
    while (lex.due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (lex.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// File: filelist.f
src/dlts_pkg.sv
src/dlts_scan.sv
src/dlts_queue.sv
src/data_language_token_scanner.sv
src/dlts_checker.sv
bench/tb_top.sv
